// ===== rtl/mpsp_pkg.sv =====
package mpsp_pkg;

  localparam int unsigned MAX_PAGES  = 16;
  localparam int unsigned IDX_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned PAD_W      = 8;
  localparam int unsigned PAD_DIM_W  = 14;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned PAGE_OUT_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDING     = 2'd2;

  localparam logic [DIM_W-1:0] PAGE_WIDTH_RST  = 13'd512;
  localparam logic [DIM_W-1:0] PAGE_HEIGHT_RST = 13'd512;
  localparam logic [PAD_W-1:0] PADDING_RST     = 8'd1;

  typedef struct packed {
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } req_t;

  typedef struct packed {
    logic                  ok;
    logic [PAGE_OUT_W-1:0] page_num;
    logic [COORD_W-1:0]    pos_x;
    logic [COORD_W-1:0]    pos_y;
    logic                  opened_page;
  } res_t;

  typedef struct packed {
    logic [COORD_W-1:0] pen_x;
    logic [COORD_W-1:0] pen_y;
    logic [COORD_W-1:0] shelf_h;
  } page_t;

  localparam int unsigned PAGE_W = $bits(page_t);

  typedef struct packed {
    logic               fit;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    page_t              next;
  } try_t;

  // One shelf-packing attempt on one page with a non-empty padded rectangle.
  function automatic try_t try_page(page_t cur, logic [PAD_DIM_W-1:0] pw,
                                    logic [PAD_DIM_W-1:0] ph,
                                    logic [DIM_W-1:0] width,
                                    logic [DIM_W-1:0] height);
    try_t               r;
    page_t              mv;
    logic [COORD_W:0]   x_end;
    logic [COORD_W:0]   y_end;
    x_end = {1'b0, cur.pen_x} + (COORD_W+1)'(pw);
    mv    = cur;
    if (x_end > (COORD_W+1)'(width)) begin
      mv.pen_x   = '0;
      mv.pen_y   = cur.pen_y + cur.shelf_h;
      mv.shelf_h = '0;
    end
    y_end  = {1'b0, mv.pen_y} + (COORD_W+1)'(ph);
    r.fit  = (y_end <= (COORD_W+1)'(height));
    r.x    = mv.pen_x;
    r.y    = mv.pen_y;
    r.next = mv;
    if (r.fit) begin
      r.next.pen_x = mv.pen_x + COORD_W'(pw);
      if (COORD_W'(ph) > mv.shelf_h) begin
        r.next.shelf_h = COORD_W'(ph);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/mpsp_if.sv =====
interface mpsp_req_if import mpsp_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mpsp_res_if import mpsp_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/multi_page_shelf_packer.sv =====
// Multi-page shelf packer for a glyph atlas.
// req_i carries one rectangle (rect_width, rect_height) per request; res_o
// returns exactly one result per request: ok, page_num, pos_x, pos_y and
// opened_page. Both channels use valid/ready; a request is taken when both
// are high. Page size and padding are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must do so only while no request is in flight, as
// the block itself does not enforce it. Pen x, pen y and shelf height of
// every page live in one RAM with a registered read. Pages are tried one
// per cycle: the read of the next page is issued while the current page
// is evaluated and written back. A zero-size rectangle tries no page;
// otherwise the open pages are tried in order up to the first fit and, if
// none fits and a page is free, one freshly opened page, so at most
// MAX_PAGES pages are tried. One request is in work at a time; without
// stalls the next request is taken in the cycle after the result loads.
// A finished result sits in the output register; the next request is taken
// while it waits, and the block holds a second result until res_o drains.
// Reset (rst_ni low, asynchronous) closes all pages and restores page size
// 512 x 512 and padding 1; the RAM needs no clearing, since page 0 is
// zeroed when it opens and any other page is read as empty when first tried.
module multi_page_shelf_packer import mpsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mpsp_req_if.sink              req_i,
  mpsp_res_if.source            res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  // configuration
  logic [DIM_W-1:0] page_width_q;
  logic [DIM_W-1:0] page_height_q;
  logic [PAD_W-1:0] padding_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_width_q  <= PAGE_WIDTH_RST;
      page_height_q <= PAGE_HEIGHT_RST;
      padding_q     <= PADDING_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAGE_WIDTH:  page_width_q  <= DIM_W'(cfg_data_i);
        CFG_PAGE_HEIGHT: page_height_q <= DIM_W'(cfg_data_i);
        CFG_PADDING:     padding_q     <= PAD_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     open_q, open_d;
  logic [IDX_W-1:0]     page_q, page_d;
  logic                 fresh_q, fresh_d;   // current page was just opened: ignore RAM
  logic                 last_q, last_d;     // current page is the extra page: no retry
  logic                 opened_q, opened_d;
  logic [PAD_DIM_W-1:0] pw_q, pw_d;
  logic [PAD_DIM_W-1:0] ph_q, ph_d;
  res_t                 pend_q, pend_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 out_q, out_d;

  // page RAM ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  page_t             ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [PAGE_W-1:0] ram_rdata;

  mpsp_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (MAX_PAGES)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic  req_fire;
  logic  zero_size;
  logic  is_last_open;
  logic  out_free;
  page_t cur_page;
  try_t  trial;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign zero_size   = (req_i.data.rect_width == '0) || (req_i.data.rect_height == '0);
  assign out_free    = !out_valid_q || res_o.ready;

  assign cur_page     = fresh_q ? page_t'('0) : page_t'(ram_rdata);
  assign trial        = try_page(cur_page, pw_q, ph_q, page_width_q, page_height_q);
  assign is_last_open = ((CNT_W'(page_q) + CNT_W'(1)) == open_q);

  // zero page 0 when it opens on request acceptance, and write back the
  // evaluated page in S_EVAL; read the next page in the same cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = page_q;
    ram_wdata = trial.next;
    ram_raddr = page_q + IDX_W'(1);
    if (state_q == S_IDLE) begin
      ram_raddr = '0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_we    = req_fire && (open_q == '0);
    end else if (state_q == S_EVAL) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    open_d      = open_q;
    page_d      = page_q;
    fresh_d     = fresh_q;
    last_d      = last_q;
    opened_d    = opened_q;
    pw_d        = pw_q;
    ph_d        = ph_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          pw_d     = PAD_DIM_W'(req_i.data.rect_width) + PAD_DIM_W'(padding_q);
          ph_d     = PAD_DIM_W'(req_i.data.rect_height) + PAD_DIM_W'(padding_q);
          page_d   = '0;
          last_d   = 1'b0;
          opened_d = (open_q == '0);
          fresh_d  = (open_q == '0);
          if (open_q == '0) begin
            open_d = CNT_W'(1);
          end
          if (zero_size) begin
            pend_d             = '0;
            pend_d.ok          = 1'b1;
            pend_d.opened_page = (open_q == '0);
            state_d            = S_PUSH;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        pend_d             = '0;
        pend_d.opened_page = opened_q;
        fresh_d            = 1'b0;
        if (trial.fit) begin
          pend_d.ok       = 1'b1;
          pend_d.page_num = PAGE_OUT_W'(page_q);
          pend_d.pos_x    = trial.x;
          pend_d.pos_y    = trial.y;
          state_d         = S_PUSH;
        end else if (last_q) begin
          state_d = S_PUSH;
        end else if (!is_last_open) begin
          page_d = page_q + IDX_W'(1);
        end else if (open_q < CNT_W'(MAX_PAGES)) begin
          // open one more page and try it once
          page_d   = IDX_W'(open_q);
          open_d   = open_q + CNT_W'(1);
          opened_d = 1'b1;
          fresh_d  = 1'b1;
          last_d   = 1'b1;
          pend_d.opened_page = 1'b1;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      open_q      <= '0;
      page_q      <= '0;
      fresh_q     <= 1'b0;
      last_q      <= 1'b0;
      opened_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      page_q      <= page_d;
      fresh_q     <= fresh_d;
      last_q      <= last_d;
      opened_q    <= opened_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q   <= pw_d;
    ph_q   <= ph_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

`ifndef SYNTH
  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= CNT_W'(MAX_PAGES))
    else $error("open page count above limit");

  a_eval_open_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (CNT_W'(page_q) < open_q))
    else $error("evaluating a page that is not open");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.data.ok) |->
      (res_o.data.pos_x == '0 && res_o.data.pos_y == '0 && res_o.data.page_num == '0))
    else $error("failed placement reports a position");

  a_open_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |=> (open_q >= $past(open_q)))
    else $error("open page count went down during a request");

  a_extra_page_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && last_q && fresh_q) |-> (CNT_W'(page_q) + CNT_W'(1) == open_q))
    else $error("extra page is not the newest open page");
`endif

endmodule

// ===== rtl/mpsp_ram.sv =====
module mpsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
